// File: src/bsa_pkg.sv
package bsa_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int WCFG_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int SLOT_W    = 8;
  localparam int OCC_W     = 9;
  localparam int STAT_W    = 2;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [ADDR_W-1:0] BASE_RST  = 32'h0000_0000;
  localparam logic [SIZE_W-1:0] SIZE_RST  = 16'd64;
  localparam logic [WCFG_W-1:0] WORDS_RST = 3'd4;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_NOT_MEMBER  = 2'd2,
    STAT_DOUBLE_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDR    = 2'd0,
    CFG_SLOT_BYTES   = 2'd1,
    CFG_WORDS_IN_USE = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_BIT,
    S_ALLOC_WR,
    S_ALLOC_ADDR,
    S_REL_START,
    S_REL_DIV,
    S_REL_RANGE,
    S_REL_RD,
    S_REL_BIT,
    S_RESULT
  } state_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ALLOC,
    RES_FULL,
    RES_NOMEM,
    RES_FREED,
    RES_DOUBLE
  } res_e;

  typedef struct packed {
    logic req_take;
    logic scan_init;
    logic scan_next;
    logic mem_rd;
    logic find_byte;
    logic find_bit;
    logic alloc_wr;
    logic rel_start;
    logic div_step;
    logic rel_range;
    logic rel_wr;
    res_e res_sel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic addr_below;
    logic word_nonzero;
    logic last_word;
    logic div_last;
    logic out_of_range;
    logic bit_free;
    logic out_free;
  } stat_t;

endpackage

// File: src/bsa_if.sv
interface bsa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [bsa_pkg::ADDR_W-1:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface bsa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bsa_pkg::STAT_W-1:0] status;
  logic [bsa_pkg::SLOT_W-1:0] slot;
  logic [bsa_pkg::ADDR_W-1:0] slot_addr;
  logic [bsa_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output slot, output slot_addr,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input slot, input slot_addr,
                  input occupancy, output ready);
endinterface

interface bsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::CFG_IDX_W-1:0] index;
  logic [bsa_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/bsa_ram.sv
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bsa_ctrl.sv
module bsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_opcode_i,
  output logic             req_ready_o,
  input  bsa_pkg::stat_t   stat_i,
  output bsa_pkg::cmd_t    cmd_o
);

  bsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = bsa_pkg::RES_NONE;
    req_ready_o   = 1'b0;
    unique case (state_q)
      bsa_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.req_take = 1'b1;
          if (bsa_pkg::opcode_e'(req_opcode_i) == bsa_pkg::OP_ALLOC) begin
            cmd_o.scan_init = 1'b1;
            state_d         = bsa_pkg::S_ALLOC_RD;
          end else begin
            state_d = bsa_pkg::S_REL_START;
          end
        end
      end
      bsa_pkg::S_ALLOC_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = bsa_pkg::S_ALLOC_CHK;
      end
      bsa_pkg::S_ALLOC_CHK: begin
        if (stat_i.word_nonzero) begin
          cmd_o.find_byte = 1'b1;
          state_d         = bsa_pkg::S_ALLOC_BIT;
        end else if (stat_i.last_word) begin
          cmd_o.res_sel = bsa_pkg::RES_FULL;
          state_d       = bsa_pkg::S_RESULT;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = bsa_pkg::S_ALLOC_RD;
        end
      end
      bsa_pkg::S_ALLOC_BIT: begin
        cmd_o.find_bit = 1'b1;
        state_d        = bsa_pkg::S_ALLOC_WR;
      end
      bsa_pkg::S_ALLOC_WR: begin
        cmd_o.alloc_wr = 1'b1;
        state_d        = bsa_pkg::S_ALLOC_ADDR;
      end
      bsa_pkg::S_ALLOC_ADDR: begin
        cmd_o.res_sel = bsa_pkg::RES_ALLOC;
        state_d       = bsa_pkg::S_RESULT;
      end
      bsa_pkg::S_REL_START: begin
        cmd_o.rel_start = 1'b1;
        if (stat_i.addr_below) begin
          cmd_o.res_sel = bsa_pkg::RES_NOMEM;
          state_d       = bsa_pkg::S_RESULT;
        end else begin
          state_d = bsa_pkg::S_REL_DIV;
        end
      end
      bsa_pkg::S_REL_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = bsa_pkg::S_REL_RANGE;
        end
      end
      bsa_pkg::S_REL_RANGE: begin
        cmd_o.rel_range = 1'b1;
        if (stat_i.out_of_range) begin
          cmd_o.res_sel = bsa_pkg::RES_NOMEM;
          state_d       = bsa_pkg::S_RESULT;
        end else begin
          state_d = bsa_pkg::S_REL_RD;
        end
      end
      bsa_pkg::S_REL_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = bsa_pkg::S_REL_BIT;
      end
      bsa_pkg::S_REL_BIT: begin
        if (stat_i.bit_free) begin
          cmd_o.res_sel = bsa_pkg::RES_DOUBLE;
        end else begin
          cmd_o.rel_wr  = 1'b1;
          cmd_o.res_sel = bsa_pkg::RES_FREED;
        end
        state_d = bsa_pkg::S_RESULT;
      end
      bsa_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: src/bsa_dp.sv
module bsa_dp #(
  parameter int SLOTS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bsa_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic [bsa_pkg::ADDR_W-1:0]      req_address_i,
  input  bsa_pkg::cmd_t                   cmd_i,
  output bsa_pkg::stat_t                  stat_o,
  input  logic                            rsp_ready_i,
  output logic                            rsp_valid_o,
  output logic [bsa_pkg::STAT_W-1:0]      rsp_status_o,
  output logic [bsa_pkg::SLOT_W-1:0]      rsp_slot_o,
  output logic [bsa_pkg::ADDR_W-1:0]      rsp_addr_o,
  output logic [bsa_pkg::OCC_W-1:0]       rsp_occ_o
);

  localparam int WORDS  = SLOTS / 64;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WN_W   = $clog2(WORDS + 1);
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int PROD_W = IDX_W + bsa_pkg::SIZE_W;

  // configuration
  logic [bsa_pkg::ADDR_W-1:0] base_q;
  logic [bsa_pkg::SIZE_W-1:0] size_q;
  logic [bsa_pkg::WCFG_W-1:0] words_q;
  logic [bsa_pkg::SIZE_W-1:0] size_eff;
  logic [WN_W-1:0]            eff_words;

  // request and work registers
  logic [bsa_pkg::ADDR_W-1:0] addr_q;
  logic [WA_W-1:0]            word_q;
  logic [bsa_pkg::WORD_W-1:0] word_buf_q;
  logic [2:0]                 byte_sel_q;
  logic [IDX_W-1:0]           idx_q;
  logic [PROD_W-1:0]          prod_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [WORDS-1:0]           vld_q;

  // divider
  logic [bsa_pkg::SIZE_W-1:0]    rem_q;
  logic [bsa_pkg::ADDR_W-1:0]    quot_q;
  logic [bsa_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [bsa_pkg::SIZE_W:0]      div_shift;
  logic [bsa_pkg::SIZE_W:0]      div_trial;

  // result staging and output
  bsa_pkg::status_e           res_status_q;
  logic [IDX_W-1:0]           res_slot_q;
  logic [bsa_pkg::ADDR_W-1:0] res_addr_q;
  logic                       out_valid_q;
  logic [bsa_pkg::STAT_W-1:0] out_status_q;
  logic [bsa_pkg::SLOT_W-1:0] out_slot_q;
  logic [bsa_pkg::ADDR_W-1:0] out_addr_q;
  logic [bsa_pkg::OCC_W-1:0]  out_occ_q;

  // bitmap memory
  logic                       ram_en;
  logic                       ram_we;
  logic [bsa_pkg::WORD_W-1:0] ram_wdata;
  logic [bsa_pkg::WORD_W-1:0] ram_rdata;
  logic [bsa_pkg::WORD_W-1:0] word_data;
  logic [bsa_pkg::WORD_W-1:0] bit_mask;

  logic [7:0] byte_nz;
  logic [2:0] first_byte;
  logic [7:0] sel_byte;
  logic [2:0] first_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= bsa_pkg::BASE_RST;
      size_q  <= bsa_pkg::SIZE_RST;
      words_q <= bsa_pkg::WORDS_RST;
    end else if (cfg_we_i) begin
      unique case (bsa_pkg::cfg_idx_e'(cfg_idx_i))
        bsa_pkg::CFG_BASE_ADDR:    base_q  <= cfg_data_i;
        bsa_pkg::CFG_SLOT_BYTES:   size_q  <= cfg_data_i[bsa_pkg::SIZE_W-1:0];
        bsa_pkg::CFG_WORDS_IN_USE: words_q <= cfg_data_i[bsa_pkg::WCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero size acts as one; word count clamped to 1..WORDS
  assign size_eff = (size_q == '0) ? bsa_pkg::SIZE_W'(1) : size_q;

  always_comb begin
    if (words_q == '0) begin
      eff_words = WN_W'(1);
    end else if (int'(words_q) > WORDS) begin
      eff_words = WN_W'(WORDS);
    end else begin
      eff_words = WN_W'(words_q);
    end
  end

  // a word never written reads as all free
  assign word_data = vld_q[word_q] ? ram_rdata : '1;
  assign bit_mask  = bsa_pkg::WORD_W'(1) << idx_q[bsa_pkg::BIT_W-1:0];

  assign ram_we    = cmd_i.alloc_wr | cmd_i.rel_wr;
  assign ram_en    = cmd_i.mem_rd | ram_we;
  assign ram_wdata = cmd_i.alloc_wr ? (word_buf_q & ~bit_mask) : (word_data | bit_mask);

  bsa_ram #(
    .WIDTH (bsa_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (word_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // lowest free slot: byte first, then bit within it
  always_comb begin
    first_byte = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      byte_nz[k] = |word_data[k*8 +: 8];
      if (byte_nz[k]) begin
        first_byte = 3'(k);
      end
    end
  end

  assign sel_byte = word_buf_q[byte_sel_q*8 +: 8];

  always_comb begin
    first_bit = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (sel_byte[k]) begin
        first_bit = 3'(k);
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  assign div_shift = {rem_q, quot_q[bsa_pkg::ADDR_W-1]};
  assign div_trial = div_shift - {1'b0, size_eff};

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_take) begin
      addr_q <= req_address_i;
    end
    if (cmd_i.scan_init) begin
      word_q <= '0;
    end else if (cmd_i.scan_next) begin
      word_q <= word_q + 1'b1;
    end else if (cmd_i.rel_range) begin
      word_q <= quot_q[bsa_pkg::BIT_W +: WA_W];
    end
    if (cmd_i.find_byte) begin
      word_buf_q <= word_data;
      byte_sel_q <= first_byte;
    end
    if (cmd_i.find_bit) begin
      idx_q <= IDX_W'({word_q, byte_sel_q, first_bit});
    end else if (cmd_i.rel_range) begin
      idx_q <= quot_q[IDX_W-1:0];
    end
    if (cmd_i.alloc_wr) begin
      prod_q <= PROD_W'(idx_q) * PROD_W'(size_eff);
    end
    if (cmd_i.rel_start) begin
      quot_q    <= addr_q - base_q;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quot_q    <= {quot_q[bsa_pkg::ADDR_W-2:0], ~div_trial[bsa_pkg::SIZE_W]};
      rem_q     <= div_trial[bsa_pkg::SIZE_W] ? div_shift[bsa_pkg::SIZE_W-1:0]
                                              : div_trial[bsa_pkg::SIZE_W-1:0];
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    unique case (cmd_i.res_sel)
      bsa_pkg::RES_ALLOC: begin
        res_status_q <= bsa_pkg::STAT_OK;
        res_slot_q   <= idx_q;
        res_addr_q   <= base_q + bsa_pkg::ADDR_W'(prod_q);
      end
      bsa_pkg::RES_FULL: begin
        res_status_q <= bsa_pkg::STAT_FULL;
        res_slot_q   <= '0;
        res_addr_q   <= '0;
      end
      bsa_pkg::RES_NOMEM: begin
        res_status_q <= bsa_pkg::STAT_NOT_MEMBER;
        res_slot_q   <= '0;
        res_addr_q   <= '0;
      end
      bsa_pkg::RES_FREED: begin
        res_status_q <= bsa_pkg::STAT_OK;
        res_slot_q   <= idx_q;
        res_addr_q   <= addr_q;
      end
      bsa_pkg::RES_DOUBLE: begin
        res_status_q <= bsa_pkg::STAT_DOUBLE_FREE;
        res_slot_q   <= idx_q;
        res_addr_q   <= addr_q;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= bsa_pkg::SLOT_W'(res_slot_q);
      out_addr_q   <= res_addr_q;
      out_occ_q    <= bsa_pkg::OCC_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_q[word_q] <= 1'b1;
      end
      if (cmd_i.alloc_wr) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.rel_wr && (cnt_q != '0)) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.addr_below   = addr_q < base_q;
    stat_o.word_nonzero = |word_data;
    stat_o.last_word    = (int'(word_q) + 1) == int'(eff_words);
    stat_o.div_last     = div_cnt_q == bsa_pkg::DIV_CNT_W'(bsa_pkg::DIV_STEPS - 1);
    stat_o.out_of_range = (quot_q >= (bsa_pkg::ADDR_W'(eff_words) << bsa_pkg::BIT_W))
                          || (rem_q != '0);
    stat_o.bit_free     = word_data[idx_q[bsa_pkg::BIT_W-1:0]];
    stat_o.out_free     = !out_valid_q || rsp_ready_i;
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_slot_o   = out_slot_q;
  assign rsp_addr_o   = out_addr_q;
  assign rsp_occ_o    = out_occ_q;

endmodule

// File: src/bitmap_slot_allocator.sv
// Slot allocator over a free bitmap of 64-bit words held in a single-port RAM.
// One request is worked at a time; each beat on req_i gives exactly one beat
// on rsp_o, held in an output register so the next request is taken while a
// response still waits. Allocate scans the bitmap words in turn, each with a
// registered RAM read and a test, then finds the free byte and bit, writes the
// word back and forms the slot address; a full pool answers once the last word
// in use tests empty. Release runs the 32-step bit-serial divider that turns
// the offset from base into a slot index; an address below base is rejected
// before the divider starts and one beyond range or off a slot boundary once
// it has finished. Words of the bitmap carry a valid flag cleared by reset, so
// an untouched word reads as all free and no clearing pass is needed after
// reset. Configuration writes are always accepted, one per cycle, and must
// only be made while the block is idle.
module bitmap_slot_allocator #(
  parameter int SLOTS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsa_cfg_if.sink      cfg_i,
  bsa_req_if.sink      req_i,
  bsa_rsp_if.source    rsp_o
);

  bsa_pkg::cmd_t  cmd;
  bsa_pkg::stat_t stat;
  logic           cfg_we;

  // configuration registers live in the datapath; the port never stalls
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  bsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  bsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .req_address_i (req_i.address),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_status_o  (rsp_o.status),
    .rsp_slot_o    (rsp_o.slot),
    .rsp_addr_o    (rsp_o.slot_addr),
    .rsp_occ_o     (rsp_o.occupancy)
  );

  // a request in flight blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another is in flight");

  // bitmap RAM: one access per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mem_rd, cmd.alloc_wr, cmd.rel_wr}))
    else $error("conflicting bitmap accesses");

  // response register is only loaded once the previous beat has gone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response overwritten before it was taken");

  // full and not-member responses carry neither slot nor address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == bsa_pkg::STAT_FULL
                     || rsp_o.status == bsa_pkg::STAT_NOT_MEMBER))
    |-> (rsp_o.slot == '0 && rsp_o.slot_addr == '0))
    else $error("rejected request returned a slot");

endmodule

// File: verif/bitmap_slot_allocator_checker.sv
module bitmap_slot_allocator_checker
  import bsa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsa_cfg_if   cfg_i,
  bsa_req_if   req_i,
  bsa_rsp_if   rsp_i,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWORDS   = SLOTS / WORD_W;
  localparam int BIT_MASK = WORD_W - 1;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  slot_addr;
    logic [OCC_W-1:0]   occupancy;
  } slot_result_t;

  logic [WORD_W-1:0] avail_bits [NWORDS];
  logic [OCC_W-1:0]  slots_taken;
  logic [ADDR_W-1:0] region_base;
  logic [SIZE_W-1:0] slot_size;
  logic [WCFG_W-1:0] word_cfg;
  slot_result_t      due_q [$];
  int                errors;

  // Works one request against the local bitmap and returns what the block owes.
  task automatic serve_request(input opcode_e op, input logic [ADDR_W-1:0] addr,
                               output slot_result_t res);
    int unsigned nwords, size, off, idx, w, b;
    logic [63:0] wide_addr;
    nwords = (word_cfg == 0) ? 1 : (word_cfg > NWORDS) ? NWORDS : word_cfg;
    size   = (slot_size == 0) ? 1 : slot_size;
    res    = '0;
    if (op == OP_ALLOC) begin
      w = 0;
      while (w < nwords && avail_bits[w] == '0) w++;
      if (w < nwords) begin
        b = 0;
        while (!avail_bits[w][b]) b++;
        idx = w * WORD_W + b;
        avail_bits[w][b] = 1'b0;
        slots_taken = slots_taken + 1'b1;
        wide_addr = 64'(region_base) + 64'(idx) * 64'(size);
        res.status    = STAT_OK;
        res.slot      = SLOT_W'(idx);
        res.slot_addr = wide_addr[ADDR_W-1:0];
      end else begin
        res.status = STAT_FULL;
      end
    end else if (addr < region_base) begin
      res.status = STAT_NOT_MEMBER;
    end else begin
      off = addr - region_base;
      idx = off / size;
      if (idx >= nwords * WORD_W || (off % size) != 0) begin
        res.status = STAT_NOT_MEMBER;
      end else begin
        w = (idx / WORD_W) & (NWORDS - 1);
        b = idx & BIT_MASK;
        res.slot      = SLOT_W'(idx);
        res.slot_addr = addr;
        if (avail_bits[w][b]) begin
          res.status = STAT_DOUBLE_FREE;
        end else begin
          avail_bits[w][b] = 1'b1;
          if (slots_taken != 0) slots_taken = slots_taken - 1'b1;
          res.status = STAT_OK;
        end
      end
    end
    res.occupancy = slots_taken;
  endtask

  function automatic int field_diff(string field, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
    if (got === want) return 0;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NWORDS; i++) avail_bits[i] = '1;
      slots_taken = '0;
      region_base = BASE_RST;
      slot_size   = SIZE_RST;
      word_cfg    = WORDS_RST;
      due_q.delete();
      errors      = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unrequested beat, expected none, got status %0d slot 0x%0h",
                   $time, rsp_i.status, rsp_i.slot);
        end else begin
          want = due_q.pop_front();
          errors += field_diff("status", want.status, rsp_i.status)
                  + field_diff("slot", want.slot, rsp_i.slot)
                  + field_diff("slot_addr", want.slot_addr, rsp_i.slot_addr)
                  + field_diff("occupancy", want.occupancy, rsp_i.occupancy);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_BASE_ADDR:    region_base = cfg_i.data[ADDR_W-1:0];
          CFG_SLOT_BYTES:   slot_size   = cfg_i.data[SIZE_W-1:0];
          CFG_WORDS_IN_USE: word_cfg    = cfg_i.data[WCFG_W-1:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        serve_request(opcode_e'(req_i.opcode), req_i.address, want);
        due_q.push_back(want);
      end
      pending_o  <= due_q.size();
      fail_cnt_o <= errors;
    end
  end

endmodule

// File: verif/bitmap_slot_allocator_tb.sv
module bitmap_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int SLOTS           = 256;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 200;
  // Every beat is bounded (release, chained stalls, long gap), so all
  // requests of the run finish far inside this.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // Register index past the end of the list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          fail_cnt;
  int          pending;
  int unsigned cycle_cnt = 0;

  // Sender pacing: beats left in the current burst, and whether this phase
  // runs back to back with no gaps at all.
  int burst_left;
  bit steady;

  // Region as last programmed, used only to aim release addresses.
  logic [ADDR_W-1:0] cur_base;
  int unsigned       cur_size;
  int unsigned       cur_span;

  bsa_cfg_if cfg_if ();
  bsa_req_if req_if ();
  bsa_rsp_if rsp_if ();

  bitmap_slot_allocator #(.SLOTS(SLOTS)) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  bitmap_slot_allocator_checker #(.SLOTS(SLOTS)) i_checker (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_if),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Leaves valid high on return so back-to-back writes need no drop in
  // between; the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Programs all three registers. Upper data bits beyond each field are
  // random so the block has to drop them.
  task automatic setup_region(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                              input logic [WCFG_W-1:0] words, input bit touch_spare);
    write_reg(CFG_BASE_ADDR, base);
    write_reg(CFG_SLOT_BYTES, {16'($urandom()), size});
    write_reg(CFG_WORDS_IN_USE, {29'($urandom()), words});
    if (touch_spare) write_reg(CFG_SPARE, $urandom());
    cfg_if.valid <= 1'b0;
    cur_base = base;
    cur_size = (size == 0) ? 1 : size;
    cur_span = WORD_W * ((words == 0) ? 1 : (words > SLOTS / WORD_W) ? SLOTS / WORD_W : words);
  endtask

  // One request beat. At the end of a burst valid drops for a random gap,
  // mostly short so it lands inside the block's own latency, sometimes long.
  task automatic send_item(input opcode_e op, input logic [ADDR_W-1:0] addr);
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        req_if.valid <= 1'b0;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8))
          @(posedge clk_i);
      end
    end
  endtask

  // Idle point: nothing outstanding, then a short margin before any
  // register write.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly slot starts, biased to the low slots where allocations cluster;
  // the rest below base, off a boundary, past the region or anywhere.
  function automatic logic [ADDR_W-1:0] release_addr();
    int unsigned roll, k;
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, cur_span - 1);
    if (roll < 60) return cur_base + k * cur_size;
    if (roll < 70 && cur_base != 0) return $urandom_range(0, cur_base - 1);
    if (roll < 80 && cur_size > 1)
      return cur_base + k * cur_size + $urandom_range(1, cur_size - 1);
    if (roll < 88) return cur_base + (cur_span + $urandom_range(0, 300)) * cur_size;
    return $urandom();
  endfunction

  task automatic random_item(input int alloc_pct);
    if ($urandom_range(0, 99) < alloc_pct) send_item(OP_ALLOC, $urandom());
    else send_item(OP_RELEASE, release_addr());
  endtask

  // Response side: runs of always-ready, runs of hard stalls, and
  // cycle-by-cycle coin flips.
  initial begin
    int unsigned roll;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      roll = $urandom_range(0, 99);
      repeat ($urandom_range(1, 60)) begin
        if (roll < 50) rsp_if.ready <= 1'b1;
        else if (roll < 70) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= 1'($urandom_range(0, 1));
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int                alloc_pct;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [WCFG_W-1:0] words;

    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.opcode  <= OP_ALLOC;
    req_if.address <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= CFG_BASE_ADDR;
    cfg_if.data    <= '0;
    burst_left = 1;
    steady     = 1'b0;
    cur_base   = BASE_RST;
    cur_size   = 32'(SIZE_RST);
    cur_span   = SLOTS;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: base 0, 64-byte slots, four words.
    send_item(OP_ALLOC, '0);              // slot 0
    send_item(OP_RELEASE, 32'h0000_3FC0); // last slot, still free: double free
    send_item(OP_RELEASE, 32'h0000_4000); // one slot past the region
    send_item(OP_RELEASE, 32'h0000_0000); // slot 0 back, count to zero
    drain();

    // Base near the top of the address space, largest slot, word count
    // above range (clamped to four).
    setup_region(32'hFFFF_FF00, 16'hFFFF, 3'd7, 1'b1);
    send_item(OP_ALLOC, 32'hFFFF_FFFF);   // address ignored on allocate
    send_item(OP_ALLOC, '0);              // slot 1, address wraps past 2^32
    send_item(OP_RELEASE, 32'hFFFF_FF00); // slot 0 freed
    send_item(OP_RELEASE, 32'hFFFF_FF00); // again: double free
    send_item(OP_RELEASE, 32'h0000_FEFF); // wrapped slot 1 sits below base
    send_item(OP_RELEASE, 32'hFFFF_FF01); // off a slot boundary
    send_item(OP_RELEASE, 32'hFFFF_FFFF); // off a boundary, top address
    drain();

    // Zero slot size acts as one byte, zero words acts as one word.
    // Slot 1 is still held from the last setting.
    setup_region('0, '0, '0, 1'b1);
    send_item(OP_ALLOC, $urandom());      // slot 0
    send_item(OP_ALLOC, $urandom());      // slot 2, slot 1 skipped
    send_item(OP_RELEASE, 32'd63);        // last slot of the word, free
    send_item(OP_RELEASE, 32'd64);        // first slot past one word
    send_item(OP_RELEASE, 32'd1);         // frees the slot held over
    send_item(OP_RELEASE, 32'd0);
    send_item(OP_RELEASE, 32'd0);         // double free
    drain();

    // Random phases. Register extremes come in the first few; the allocate
    // share rotates so some phases fill the pool and others empty it.
    for (int p = 0; p < PHASES; p++) begin
      steady    = (p % 3 == 2);
      alloc_pct = 40 + 15 * (p % 4);
      case (p % 4)
        0:       base = '0;
        1:       base = '1;
        2:       base = $urandom();
        default: base = $urandom_range(0, 32'h0000_FFFF);
      endcase
      case (p % 5)
        0:       size = 16'd1;
        1:       size = '1;
        2:       size = '0;
        3:       size = SIZE_W'($urandom_range(1, 256));
        default: size = SIZE_W'($urandom_range(1, 65535));
      endcase
      case (p)
        0:       words = 3'd1;
        1:       words = 3'd4;
        2:       words = 3'd0;
        3:       words = 3'd7;
        default: words = WCFG_W'($urandom_range(0, 7));
      endcase
      setup_region(base, size, words, p[0]);
      repeat (ITEMS_PER_PHASE) random_item(alloc_pct);
      drain();
    end

    // Margin for anything the block might still push out unasked.
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bsa_pkg.sv
src/bsa_if.sv
src/bsa_ram.sv
src/bsa_ctrl.sv
src/bsa_dp.sv
src/bitmap_slot_allocator.sv
verif/bitmap_slot_allocator_checker.sv
verif/bitmap_slot_allocator_tb.sv
